// File: rtl/core/step_sequencer_tone_gen_macros.svh
// ----------------------------------------------------------------------------
// step sequencer tone generator assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_TONE_GEN_MACROS_SVH
`define STEP_SEQUENCER_TONE_GEN_MACROS_SVH

// same-cycle implication
`define SSTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstg assertion failed");

// next-cycle implication
`define SSTG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstg assertion failed");

`endif

// File: rtl/core/sstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstg_pkg
// types, constants and the sine table of the step sequencer tone generator
// ----------------------------------------------------------------------------
package sstg_pkg;

    localparam int MAX_STEPS       = 32;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;

    localparam int STEP_BITS    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int NSTEPS_W     = 6;
    localparam int STEP_CMP_W   = (STEP_BITS + 1 > NSTEPS_W) ? STEP_BITS + 1 : NSTEPS_W;
    localparam int STEP_OUT_W   = 5;
    localparam int SAMPLE_W     = 16;
    localparam int INC_W        = 32;
    localparam int COUNT_W      = 24;
    localparam int CFG_DATA_W   = 32;

    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int QUARTER_N    = 1 << QUARTER_BITS;
    localparam int TWO_QUARTER  = 2 * QUARTER_N;
    localparam int FRAC_BITS    = 28;
    localparam longint unsigned PI_Q28 = 64'd843314857;
    localparam int FULL_SCALE   = 32767;

    localparam logic [INC_W-1:0]    SINE_INC_RST   = 32'd42852281;
    localparam logic [INC_W-1:0]    SQUARE_INC_RST = 32'd75965407;
    localparam logic [COUNT_W-1:0]  SPS_RST        = 24'd11025;
    localparam logic [NSTEPS_W-1:0] NSTEPS_RST     = 6'd20;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_KEY  = 1'b1
    } op_t;

    typedef enum logic {
        VOICE_SINE   = 1'b0,
        VOICE_SQUARE = 1'b1
    } voice_t;

    typedef enum logic [1:0] {
        REG_SINE_INC   = 2'd0,
        REG_SQUARE_INC = 2'd1,
        REG_SPS        = 2'd2,
        REG_NUM_STEPS  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        op_t    op;
        voice_t voice;
    } sstg_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [STEP_OUT_W-1:0]      step;
        logic                       sine_on;
        logic                       square_on;
    } sstg_out_t;

    typedef logic [14:0] quarter_tab_t [QUARTER_N];

    // first-quarter sine magnitude, taylor series through x^13 in q4.28
    function automatic logic [14:0] quarter_sine(input int unsigned r);
        longint unsigned x;
        longint unsigned s;
        longint unsigned t;
        longint unsigned v;
        logic [14:0]     res;
        x = longint'(r);
        x = (x * PI_Q28 + QUARTER_N) / TWO_QUARTER;
        s = x;
        t = x;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 6;
        s = s - t;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 20;
        s = s + t;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 42;
        s = s - t;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 72;
        s = s + t;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 110;
        s = s - t;
        t = (((t * x) >> FRAC_BITS) * x) >> FRAC_BITS;
        t = t / 156;
        s = s + t;
        v = (s * FULL_SCALE + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (v > FULL_SCALE)
        begin
            res = 15'(FULL_SCALE);
        end
        else
        begin
            res = 15'(v);
        end
        return res;
    endfunction

    function automatic quarter_tab_t build_quarter_tab();
        quarter_tab_t tab;
        for (int i = 0; i < QUARTER_N; i++)
        begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    localparam quarter_tab_t QUARTER_TAB  = build_quarter_tab();
    localparam logic [14:0]  QUARTER_PEAK = quarter_sine(QUARTER_N);

    // full-wave sine sample from the quarter table
    function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [1:0]                 quad;
        logic [QUARTER_BITS-1:0]    r;
        logic [QUARTER_BITS-1:0]    rm;
        logic [14:0]                mag;
        logic signed [SAMPLE_W-1:0] val;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[QUARTER_BITS-1:0];
        rm   = ~r + 1'b1;
        if (quad[0])
        begin
            mag = (r == '0) ? QUARTER_PEAK : QUARTER_TAB[rm];
        end
        else
        begin
            mag = QUARTER_TAB[r];
        end
        val = signed'({1'b0, mag});
        if (quad[1])
        begin
            val = -val;
        end
        return val;
    endfunction

endpackage

// File: rtl/core/step_sequencer_tone_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_tone_gen
// two-voice step sequencer: sine and square dds voices gated by a pattern
// output: the sample of an accepted tick item is registered in the output
//   register and shows on out_item in the cycle after the tick is accepted
// throughput: one item per cycle, ticks and keys alike; the output register
//   is the only stage and in_stall follows a stalled full output register
// reset: rst_n clears pattern, counters, phases and enables at once and loads
//   the configuration registers with their defaults; no clearing pass
// ----------------------------------------------------------------------------
module step_sequencer_tone_gen
    import sstg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sstg_in_t              in_item,
    // sample output
    output logic                  out_valid,
    input  logic                  out_stall,
    output sstg_out_t             out_item,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [INC_W-1:0]    sine_inc_reg;
    logic [INC_W-1:0]    square_inc_reg;
    logic [COUNT_W-1:0]  sps_reg;
    logic [NSTEPS_W-1:0] nsteps_reg;

    // sequencer state
    logic [1:0]            pattern_reg [MAX_STEPS];
    logic [STEP_BITS-1:0]  step_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [1:0]            enable_reg;
    logic [PHASE_BITS-1:0] sine_phase_reg;
    logic [PHASE_BITS-1:0] square_phase_reg;

    // enables of the current step still to be loaded at the next tick; phases
    // of voices that are on in the loaded enables are zeroed at that load too
    logic                  pending_reg;
    // set after a step change: key toggles since then are tracked in mask so
    // the load sees the pattern as it was at the change
    logic                  track_reg;
    logic [1:0]            mask_reg;

    logic                  out_valid_reg;
    sstg_out_t             out_item_reg;

    // next values
    logic [STEP_BITS-1:0]  step_next;
    logic [COUNT_W-1:0]    count_next;
    logic [1:0]            enable_next;
    logic [PHASE_BITS-1:0] sine_phase_next;
    logic [PHASE_BITS-1:0] square_phase_next;
    logic                  pending_next;
    logic                  track_next;
    logic [1:0]            mask_next;
    logic                  out_valid_next;

    // datapath
    logic                       in_take;
    logic                       is_tick;
    logic                       is_key;
    logic [1:0]                 key_bit;
    logic [1:0]                 cur_pat;
    logic [1:0]                 en_eff;
    logic [PHASE_BITS-1:0]      sine_ph_eff;
    logic [PHASE_BITS-1:0]      square_ph_eff;
    logic signed [SAMPLE_W-1:0] sine_term;
    logic signed [SAMPLE_W-1:0] square_term;
    logic signed [SAMPLE_W+1:0] mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;
    logic [COUNT_W-1:0]         sps_eff;
    logic [COUNT_W-1:0]         count_inc;
    logic                       step_wrap;
    logic [STEP_CMP_W-1:0]      nsteps_ext;
    logic [STEP_CMP_W-1:0]      steps_eff;
    logic [STEP_BITS:0]         step_plus;
    logic [STEP_BITS-1:0]       step_adv;
    logic                       step_changed;
    sstg_out_t                  result;

    // handshakes: a full output register that is stalled holds off input
    assign in_take   = in_valid & ~in_stall;
    assign in_stall  = out_valid_reg & out_stall;
    assign cfg_ready = 1'b1;
    assign is_tick   = in_take & (in_item.op == OP_TICK);
    assign is_key    = in_take & (in_item.op == OP_KEY);
    assign key_bit   = (in_item.voice == VOICE_SINE) ? 2'b01 : 2'b10;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_inc_reg   <= SINE_INC_RST;
            square_inc_reg <= SQUARE_INC_RST;
            sps_reg        <= SPS_RST;
            nsteps_reg     <= NSTEPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SINE_INC:   sine_inc_reg   <= cfg_data;
                REG_SQUARE_INC: square_inc_reg <= cfg_data;
                REG_SPS:        sps_reg        <= cfg_data[COUNT_W-1:0];
                REG_NUM_STEPS:  nsteps_reg     <= cfg_data[NSTEPS_W-1:0];
                default:        sine_inc_reg   <= sine_inc_reg;
            endcase
        end
    end

    // enables and phases the sample is made with
    always_comb
    begin
        cur_pat = pattern_reg[step_reg];
        if (pending_reg)
        begin
            en_eff = cur_pat ^ mask_reg;
        end
        else
        begin
            en_eff = enable_reg;
        end
        sine_ph_eff   = (pending_reg && en_eff[0]) ? '0 : sine_phase_reg;
        square_ph_eff = (pending_reg && en_eff[1]) ? '0 : square_phase_reg;
    end

    // voice mix with saturation
    always_comb
    begin
        sine_term = en_eff[0]
                  ? sine_lookup(sine_ph_eff[PHASE_BITS-1 -: SINE_TABLE_BITS])
                  : '0;
        if (!en_eff[1])
        begin
            square_term = '0;
        end
        else if (square_ph_eff[PHASE_BITS-1])
        begin
            square_term = -SAMPLE_W'(FULL_SCALE);
        end
        else
        begin
            square_term = SAMPLE_W'(FULL_SCALE);
        end
        mix_sum = (SAMPLE_W+2)'(sine_term) + (SAMPLE_W+2)'(square_term);
        if (mix_sum > (SAMPLE_W+2)'(FULL_SCALE))
        begin
            mix_sat = SAMPLE_W'(FULL_SCALE);
        end
        else if (mix_sum < -(SAMPLE_W+2)'(FULL_SCALE + 1))
        begin
            mix_sat = -SAMPLE_W'(FULL_SCALE) - SAMPLE_W'(1);
        end
        else
        begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
        result.sample    = mix_sat;
        result.step      = STEP_OUT_W'(step_reg);
        result.sine_on   = en_eff[0];
        result.square_on = en_eff[1];
    end

    // sample counter and step advance; zero registers read as one, step
    // count clamps to the pattern depth
    always_comb
    begin
        sps_eff    = (sps_reg == '0) ? COUNT_W'(1) : sps_reg;
        count_inc  = count_reg + COUNT_W'(1);
        step_wrap  = (count_inc >= sps_eff);
        nsteps_ext = STEP_CMP_W'(nsteps_reg);
        if (nsteps_ext == '0)
        begin
            steps_eff = STEP_CMP_W'(1);
        end
        else if (nsteps_ext > STEP_CMP_W'(MAX_STEPS))
        begin
            steps_eff = STEP_CMP_W'(MAX_STEPS);
        end
        else
        begin
            steps_eff = nsteps_ext;
        end
        step_plus = {1'b0, step_reg} + (STEP_BITS+1)'(1);
        if (STEP_CMP_W'(step_plus) >= steps_eff)
        begin
            step_adv = '0;
        end
        else
        begin
            step_adv = step_plus[STEP_BITS-1:0];
        end
        step_changed = (step_adv != step_reg);
    end

    // state update
    always_comb
    begin
        step_next         = step_reg;
        count_next        = count_reg;
        enable_next       = enable_reg;
        sine_phase_next   = sine_phase_reg;
        square_phase_next = square_phase_reg;
        pending_next      = pending_reg;
        track_next        = track_reg;
        mask_next         = mask_reg;
        out_valid_next    = out_valid_reg & out_stall;
        if (is_tick)
        begin
            out_valid_next    = 1'b1;
            enable_next       = en_eff;
            sine_phase_next   = sine_ph_eff + PHASE_BITS'(sine_inc_reg);
            square_phase_next = square_ph_eff + PHASE_BITS'(square_inc_reg);
            count_next        = step_wrap ? '0 : count_inc;
            pending_next      = 1'b0;
            track_next        = 1'b0;
            mask_next         = '0;
            if (step_wrap)
            begin
                step_next = step_adv;
                if (step_changed)
                begin
                    pending_next = 1'b1;
                    track_next   = 1'b1;
                end
            end
        end
        else if (is_key && track_reg)
        begin
            mask_next = mask_reg ^ key_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            count_reg        <= '0;
            enable_reg       <= '0;
            sine_phase_reg   <= '0;
            square_phase_reg <= '0;
            pending_reg      <= 1'b1;
            track_reg        <= 1'b0;
            mask_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            count_reg        <= count_next;
            enable_reg       <= enable_next;
            sine_phase_reg   <= sine_phase_next;
            square_phase_reg <= square_phase_next;
            pending_reg      <= pending_next;
            track_reg        <= track_next;
            mask_reg         <= mask_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // pattern: key items toggle one voice bit of the current step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STEPS; i++)
            begin
                pattern_reg[i] <= '0;
            end
        end
        else if (is_key)
        begin
            pattern_reg[step_reg] <= pattern_reg[step_reg] ^ key_bit;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `include "step_sequencer_tone_gen_macros.svh"

    `SSTG_ASSERT_NXT(a_tick_gives_sample, clk, rst_n, is_tick, out_valid_reg)
    `SSTG_ASSERT_NXT(a_key_gives_none, clk, rst_n, is_key, !out_valid_reg)
    `SSTG_ASSERT_IMP(a_track_needs_pending, clk, rst_n, track_reg, pending_reg)
    `SSTG_ASSERT_IMP(a_mask_needs_track, clk, rst_n, mask_reg != 2'b00, track_reg)
    `SSTG_ASSERT_IMP(a_silent_when_off, clk, rst_n,
        out_valid_reg && !out_item_reg.sine_on && !out_item_reg.square_on,
        out_item_reg.sample == '0)

endmodule
